/* hw/rtl/cc20_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cc20_pkg;

    typedef logic [31:0] word_t;
    typedef logic [63:0] dword_t;
    typedef word_t [15:0] matrix_t;

    // Block function constants
    localparam word_t SIGMA0 = 32'h6170_7865;
    localparam word_t SIGMA1 = 32'h3320_646e;
    localparam word_t SIGMA2 = 32'h7962_2d32;
    localparam word_t SIGMA3 = 32'h6b20_6574;

    localparam int ROUNDS   = 20;
    localparam int ROUND_W  = $clog2(ROUNDS);
    localparam int WORDS    = 8;
    localparam int POS_W    = $clog2(WORDS);
    localparam int COUNT_W  = 4;
    localparam int CFG_ADDR_W = 3;

    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(WORDS);

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY0     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY1     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY2     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY3     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_NONCE_LO = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_NONCE_HI = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_INIT_CTR = 3'd6;

    typedef struct packed {
        dword_t key0;
        dword_t key1;
        dword_t key2;
        dword_t key3;
        dword_t nonce_lo;
        word_t  nonce_hi;
        word_t  init_ctr;
    } cc20_cfg_t;

    // Top level to block engine
    typedef struct packed {
        logic             start;
        word_t            counter;
        logic [POS_W-1:0] sel;
    } cc20_core_req_t;

    // Block engine to top level
    typedef struct packed {
        logic done;
    } cc20_core_sts_t;

    function automatic word_t rotl(word_t v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // Initial 4x4 state for one block
    function automatic matrix_t make_init(cc20_cfg_t c, word_t counter);
        matrix_t m;
        m[0]  = SIGMA0;
        m[1]  = SIGMA1;
        m[2]  = SIGMA2;
        m[3]  = SIGMA3;
        m[4]  = c.key0[31:0];
        m[5]  = c.key0[63:32];
        m[6]  = c.key1[31:0];
        m[7]  = c.key1[63:32];
        m[8]  = c.key2[31:0];
        m[9]  = c.key2[63:32];
        m[10] = c.key3[31:0];
        m[11] = c.key3[63:32];
        m[12] = counter;
        m[13] = c.nonce_lo[31:0];
        m[14] = c.nonce_lo[63:32];
        m[15] = c.nonce_hi;
        return m;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/cc20_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// Message word request
interface cc20_in_if;
    import cc20_pkg::*;
    logic               valid;
    logic               ready;
    dword_t             data_in;
    logic               start_req;
    logic [COUNT_W-1:0] byte_count;

    modport source (output valid, output data_in, output start_req, output byte_count,
                    input ready);
    modport sink   (input valid, input data_in, input start_req, input byte_count,
                    output ready);
endinterface

// Result word request
interface cc20_out_if;
    import cc20_pkg::*;
    logic               valid;
    logic               ready;
    dword_t             data_out;
    logic [COUNT_W-1:0] out_count;

    modport source (output valid, output data_out, output out_count, input ready);
    modport sink   (input valid, input data_out, input out_count, output ready);
endinterface

// Register write request
interface cc20_cfg_if;
    import cc20_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    dword_t                data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/cc20_qr.sv */
`timescale 1ns / 1ps
`default_nettype none

// Half of a quarter-round: two add/xor/rotate steps.
// second = 0 uses rotations 16 and 12, second = 1 uses 8 and 7.
module cc20_qr
    import cc20_pkg::*;
(
    input  word_t a,
    input  word_t b,
    input  word_t c,
    input  word_t d,
    input  logic  second,
    output word_t a_out,
    output word_t b_out,
    output word_t c_out,
    output word_t d_out
);

    word_t a1;
    word_t dx;
    word_t d1;
    word_t c1;
    word_t bx;

    always_comb
    begin
        a1 = a + b;
        dx = d ^ a1;
        d1 = second ? rotl(dx, 8) : rotl(dx, 16);
        c1 = c + d1;
        bx = b ^ c1;
        a_out = a1;
        d_out = d1;
        c_out = c1;
        b_out = second ? rotl(bx, 7) : rotl(bx, 12);
    end

endmodule

`default_nettype wire

/* hw/rtl/cc20_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Block engine: four half-quarter-round lanes reused for 20 rounds, each
// round done as a first and a second half, then a feed-forward add.
module cc20_core
    import cc20_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  cc20_cfg_t      cfg,
    input  cc20_core_req_t req,
    output cc20_core_sts_t sts,
    output dword_t         ks_word
);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_RUN  = 2'd1;
    localparam logic [1:0] C_ADD  = 2'd2;

    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);

    logic [1:0]         state_reg, state_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic               half_reg, half_next;
    logic               done_reg, done_next;
    word_t              ctr_reg, ctr_next;
    matrix_t            x_reg, x_next;

    matrix_t            init;
    logic               diag;
    logic [3:0]         ia [4];
    logic [3:0]         ib [4];
    logic [3:0]         ic [4];
    logic [3:0]         id [4];
    word_t              qa [4];
    word_t              qb [4];
    word_t              qc [4];
    word_t              qd [4];

    assign init = make_init(cfg, ctr_reg);
    assign diag = round_reg[0];

    // Lane operand indexes: columns on even rounds, diagonals on odd
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            ia[i] = {2'b00, 2'(i)};
            ib[i] = {2'b01, 2'(i) + {1'b0, diag}};
            ic[i] = {2'b10, 2'(i) + {diag, 1'b0}};
            id[i] = {2'b11, 2'(i) + {diag, diag}};
        end
    end

    // Shared round lanes
    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        cc20_qr u_qr (
            .a      (x_reg[ia[g]]),
            .b      (x_reg[ib[g]]),
            .c      (x_reg[ic[g]]),
            .d      (x_reg[id[g]]),
            .second (half_reg),
            .a_out  (qa[g]),
            .b_out  (qb[g]),
            .c_out  (qc[g]),
            .d_out  (qd[g])
        );
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        half_next  = half_reg;
        done_next  = 1'b0;
        ctr_next   = ctr_reg;
        x_next     = x_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (req.start)
                begin
                    ctr_next   = req.counter;
                    x_next     = make_init(cfg, req.counter);
                    round_next = '0;
                    half_next  = 1'b0;
                    state_next = C_RUN;
                end
            end
            C_RUN:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    x_next[ia[i]] = qa[i];
                    x_next[ib[i]] = qb[i];
                    x_next[ic[i]] = qc[i];
                    x_next[id[i]] = qd[i];
                end
                half_next = ~half_reg;
                if (half_reg)
                begin
                    if (round_reg == LAST_ROUND)
                    begin
                        state_next = C_ADD;
                    end
                    else
                    begin
                        round_next = round_reg + 1'b1;
                    end
                end
            end
            C_ADD:
            begin
                for (int k = 0; k < 16; k++)
                begin
                    x_next[k] = x_reg[k] + init[k];
                end
                done_next  = 1'b1;
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            round_reg <= '0;
            half_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            half_reg  <= half_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctr_reg <= ctr_next;
        x_reg   <= x_next;
    end

    assign sts.done = done_reg;
    assign ks_word  = {x_reg[{req.sel, 1'b1}], x_reg[{req.sel, 1'b0}]};

endmodule

`default_nettype wire

/* hw/rtl/chacha20_stream_xor.sv */
// Channel  Dir  Payload                              Accept
// din      in   data_in[64] start_req byte_count[4]  valid && ready
// dout     out  data_out[64] out_count[4]            valid && ready
// cfg      in   addr[3] data[64]                     valid && ready (ready always 1)
//
// Word 0 of a 64-byte block waits on the block engine (rounds on four
// half-quarter-round lanes, one add, the done hand-off) before the output
// register; other words go straight to the output register.
// din.ready is high only while no word is held; one result may wait in the
// output register while the next word is taken, and a stalled output holds
// that word. Reset clears control state and the configuration registers.
`timescale 1ns / 1ps
`default_nettype none

module chacha20_stream_xor
    import cc20_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    cc20_in_if.sink    din,
    cc20_out_if.source dout,
    cc20_cfg_if.sink   cfg
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_GEN  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]         state_reg, state_next;
    word_t              ctr_reg, ctr_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   cur_pos_reg, cur_pos_next;
    dword_t             data_reg, data_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               ovalid_reg, ovalid_next;
    dword_t             odata_reg, odata_next;
    logic [COUNT_W-1:0] ocnt_reg, ocnt_next;
    cc20_cfg_t          cfg_reg, cfg_next;

    logic               accept;
    word_t              ctr_eff;
    logic [POS_W-1:0]   pos_eff;
    dword_t             mask;
    dword_t             ks_word;
    cc20_core_req_t     core_req;
    cc20_core_sts_t     core_sts;

    assign accept    = din.valid && din.ready;
    assign din.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign ctr_eff = din.start_req ? cfg_reg.init_ctr : ctr_reg;
    assign pos_eff = din.start_req ? '0 : pos_reg;

    assign core_req.start   = accept && (pos_eff == '0);
    assign core_req.counter = ctr_eff;
    assign core_req.sel     = cur_pos_reg;

    cc20_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .req     (core_req),
        .sts     (core_sts),
        .ks_word (ks_word)
    );

    // Byte mask from the clamped count
    always_comb
    begin
        for (int i = 0; i < WORDS; i++)
        begin
            mask[8*i +: 8] = (COUNT_W'(i) < cnt_reg) ? 8'hff : 8'h00;
        end
    end

    // Register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.addr)
                CFG_KEY0:     cfg_next.key0     = cfg.data;
                CFG_KEY1:     cfg_next.key1     = cfg.data;
                CFG_KEY2:     cfg_next.key2     = cfg.data;
                CFG_KEY3:     cfg_next.key3     = cfg.data;
                CFG_NONCE_LO: cfg_next.nonce_lo = cfg.data;
                CFG_NONCE_HI: cfg_next.nonce_hi = cfg.data[31:0];
                CFG_INIT_CTR: cfg_next.init_ctr = cfg.data[31:0];
                default:      cfg_next          = cfg_reg;
            endcase
        end
    end

    // Word sequencer
    always_comb
    begin
        state_next   = state_reg;
        ctr_next     = ctr_reg;
        pos_next     = pos_reg;
        cur_pos_next = cur_pos_reg;
        data_next    = data_reg;
        cnt_next     = cnt_reg;
        ovalid_next  = ovalid_reg && !dout.ready;
        odata_next   = odata_reg;
        ocnt_next    = ocnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    data_next    = din.data_in;
                    cnt_next     = (din.byte_count > FULL_COUNT) ? FULL_COUNT
                                                                 : din.byte_count;
                    cur_pos_next = pos_eff;
                    pos_next     = pos_eff + 1'b1;
                    ctr_next     = (pos_eff == POS_W'(WORDS - 1)) ? ctr_eff + 1'b1
                                                                  : ctr_eff;
                    state_next   = (pos_eff == '0) ? S_GEN : S_EMIT;
                end
            end
            S_GEN:
            begin
                if (core_sts.done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!ovalid_reg || dout.ready)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = (data_reg ^ ks_word) & mask;
                    ocnt_next   = cnt_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ctr_reg    <= '0;
            pos_reg    <= '0;
            ovalid_reg <= 1'b0;
            cfg_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ctr_reg    <= ctr_next;
            pos_reg    <= pos_next;
            ovalid_reg <= ovalid_next;
            cfg_reg    <= cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_pos_reg <= cur_pos_next;
        data_reg    <= data_next;
        cnt_reg     <= cnt_next;
        odata_reg   <= odata_next;
        ocnt_reg    <= ocnt_next;
    end

    assign dout.valid     = ovalid_reg;
    assign dout.data_out  = odata_reg;
    assign dout.out_count = ocnt_reg;

endmodule

`default_nettype wire

/* hw/rtl/cc20_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module cc20_checker
    import cc20_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               din_valid,
    input  logic               din_ready,
    input  logic               dout_valid,
    input  logic               dout_ready,
    input  dword_t             dout_data,
    input  logic [COUNT_W-1:0] dout_count
);

    logic [1:0] pending_reg, pending_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = din_valid && din_ready;
    assign out_acc = dout_valid && dout_ready;

    // Words taken but not yet delivered
    always_comb
    begin
        pending_next = pending_reg + {1'b0, in_acc} - {1'b0, out_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dout_valid && !dout_ready |=> dout_valid && $stable(dout_data))
        else $error("result dropped while stalled");

    // Only one word is worked on at a time
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !din_ready)
        else $error("second word taken while busy");

    // No result without a word behind it, and at most two in flight
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg == 2'd0) |-> !dout_valid)
        else $error("result with no pending word");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("too many words in flight");

    // Empty words come out as zero
    a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        dout_valid && (dout_count == '0) |-> (dout_data == '0))
        else $error("empty word carries data");

endmodule

bind chacha20_stream_xor cc20_checker u_cc20_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .din_valid  (din.valid),
    .din_ready  (din.ready),
    .dout_valid (dout.valid),
    .dout_ready (dout.ready),
    .dout_data  (dout.data_out),
    .dout_count (dout.out_count)
);

`default_nettype wire

/* verif/cc20_xor_scoreboard.sv */
`timescale 1ns / 1ps

// Watches the register, message and result channels, keeps its own copy of
// the cipher state and checks every result request in order.
module cc20_xor_scoreboard
    import cc20_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    cc20_in_if   din,
    cc20_out_if  dout,
    cc20_cfg_if  cfg,
    output int   pending,
    output int   fail_count
);

    typedef struct packed {
        dword_t             data;
        logic [COUNT_W-1:0] count;
    } xor_word_t;

    typedef dword_t [WORDS-1:0] ks_block_t;

    cc20_cfg_t        regs;
    word_t            blk_ctr;
    logic [POS_W-1:0] word_pos;
    ks_block_t        ks;
    xor_word_t        expected_words[$];

    // One quarter round on four words of the state
    function automatic matrix_t qround(matrix_t m, int a, int b, int c, int d);
        m[a] = m[a] + m[b]; m[d] = m[d] ^ m[a]; m[d] = {m[d][15:0], m[d][31:16]};
        m[c] = m[c] + m[d]; m[b] = m[b] ^ m[c]; m[b] = {m[b][19:0], m[b][31:20]};
        m[a] = m[a] + m[b]; m[d] = m[d] ^ m[a]; m[d] = {m[d][23:0], m[d][31:24]};
        m[c] = m[c] + m[d]; m[b] = m[b] ^ m[c]; m[b] = {m[b][24:0], m[b][31:25]};
        return m;
    endfunction

    // Full block function: 10 double rounds plus feed-forward
    function automatic ks_block_t chacha_block(cc20_cfg_t c, word_t ctr);
        matrix_t   x0;
        matrix_t   x;
        ks_block_t b;
        int        i;
        x0[0]  = SIGMA0;
        x0[1]  = SIGMA1;
        x0[2]  = SIGMA2;
        x0[3]  = SIGMA3;
        x0[4]  = c.key0[31:0];
        x0[5]  = c.key0[63:32];
        x0[6]  = c.key1[31:0];
        x0[7]  = c.key1[63:32];
        x0[8]  = c.key2[31:0];
        x0[9]  = c.key2[63:32];
        x0[10] = c.key3[31:0];
        x0[11] = c.key3[63:32];
        x0[12] = ctr;
        x0[13] = c.nonce_lo[31:0];
        x0[14] = c.nonce_lo[63:32];
        x0[15] = c.nonce_hi;
        x = x0;
        for (i = 0; i < ROUNDS / 2; i++)
        begin
            // column round
            x = qround(x, 0, 4, 8, 12);
            x = qround(x, 1, 5, 9, 13);
            x = qround(x, 2, 6, 10, 14);
            x = qround(x, 3, 7, 11, 15);
            // diagonal round
            x = qround(x, 0, 5, 10, 15);
            x = qround(x, 1, 6, 11, 12);
            x = qround(x, 2, 7, 8, 13);
            x = qround(x, 3, 4, 9, 14);
        end
        for (i = 0; i < 16; i++)
            x[i] = x[i] + x0[i];
        for (i = 0; i < WORDS; i++)
            b[i] = {x[2 * i + 1], x[2 * i]};
        return b;
    endfunction

    // Advance the cipher state by one message word, return the expected result
    function automatic xor_word_t encrypt_word(dword_t d, logic s, logic [COUNT_W-1:0] bc);
        logic [COUNT_W-1:0] n;
        dword_t             mask;
        xor_word_t          r;
        if (s)
        begin
            blk_ctr  = regs.init_ctr;
            word_pos = '0;
        end
        n = (bc > FULL_COUNT) ? FULL_COUNT : bc;
        if (word_pos == '0)
            ks = chacha_block(regs, blk_ctr);
        mask    = (n == FULL_COUNT) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
        r.data  = (d ^ ks[word_pos]) & mask;
        r.count = n;
        // counter steps after the last word of a block, wraps silently
        if (word_pos == '1)
            blk_ctr = blk_ctr + 32'd1;
        word_pos = word_pos + 1'b1;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        xor_word_t exp_w;
        if (!rst_n)
        begin
            regs       = '0;
            blk_ctr    = '0;
            word_pos   = '0;
            ks         = '0;
            expected_words.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // register write request
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.addr)
                    CFG_KEY0:     regs.key0     = cfg.data;
                    CFG_KEY1:     regs.key1     = cfg.data;
                    CFG_KEY2:     regs.key2     = cfg.data;
                    CFG_KEY3:     regs.key3     = cfg.data;
                    CFG_NONCE_LO: regs.nonce_lo = cfg.data;
                    CFG_NONCE_HI: regs.nonce_hi = cfg.data[31:0];
                    CFG_INIT_CTR: regs.init_ctr = cfg.data[31:0];
                    default:      ;
                endcase
            end

            // result request: compare against the oldest prediction
            if (dout.valid && dout.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result data_out=%h out_count=%0d", $time,
                             dout.data_out, dout.out_count);
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (dout.data_out !== exp_w.data)
                    begin
                        fail_count++;
                        $display("%0t: data_out expected %h actual %h", $time,
                                 exp_w.data, dout.data_out);
                    end
                    if (dout.out_count !== exp_w.count)
                    begin
                        fail_count++;
                        $display("%0t: out_count expected %0d actual %0d", $time,
                                 exp_w.count, dout.out_count);
                    end
                end
            end

            // message request
            if (din.valid && din.ready)
                expected_words.push_back(encrypt_word(din.data_in, din.start_req,
                                                      din.byte_count));

            pending = expected_words.size();
        end
    end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import cc20_pkg::*;

    localparam int ITEMS = 1050;
    localparam int LIMIT = 1_000_000;
    localparam int DRAIN = 50;

    // unmapped register slot, writes must be ignored
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 3'd7;

    logic clk;
    logic rst_n;
    int   pending;
    int   fail_count;
    int   cycles;
    int   sent;
    int   n_starts;
    int   n_writes;
    int   n_phases;
    bit   eager;

    cc20_in_if  din ();
    cc20_out_if dout ();
    cc20_cfg_if cfg ();

    chacha20_stream_xor dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din),
        .dout  (dout),
        .cfg   (cfg)
    );

    cc20_xor_scoreboard sb (
        .clk        (clk),
        .rst_n      (rst_n),
        .din        (din),
        .dout       (dout),
        .cfg        (cfg),
        .pending    (pending),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side back-pressure: mostly short stalls, a few long ones
    initial
    begin
        int hold;
        int r;
        dout.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                dout.ready <= 1'b1;
                hold = $urandom_range(1, 20);
            end
            else if (r < 60)
            begin
                dout.ready <= 1'b1;
                hold = $urandom_range(50, 200);
            end
            else if (r < 88)
            begin
                dout.ready <= 1'b0;
                hold = $urandom_range(1, 3);
            end
            else if (r < 98)
            begin
                dout.ready <= 1'b0;
                hold = $urandom_range(4, 12);
            end
            else
            begin
                dout.ready <= 1'b0;
                hold = $urandom_range(20, 60);
            end
            repeat (hold) @(posedge clk);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic dword_t rand_dword();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    // Random register set, with the all-zero and all-one corners now and then
    function automatic cc20_cfg_t rand_settings();
        cc20_cfg_t s;
        int        r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        s.key0     = rand_dword();
        s.key1     = rand_dword();
        s.key2     = rand_dword();
        s.key3     = rand_dword();
        s.nonce_lo = rand_dword();
        s.nonce_hi = 32'(rand_dword());
        r = $urandom_range(0, 9);
        if (r < 3)
            s.init_ctr = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
        else if (r == 3)
            s.init_ctr = '0;
        else
            s.init_ctr = $urandom;
        return s;
    endfunction

    // One message word request; returns at the edge where it is taken
    task automatic send_req(dword_t d, logic s, logic [COUNT_W-1:0] bc);
        int gap;
        gap = eager ? 0 : pick_gap();
        if (gap > 0)
        begin
            din.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        din.valid      <= 1'b1;
        din.data_in    <= d;
        din.start_req  <= s;
        din.byte_count <= bc;
        @(posedge clk);
        while (!din.ready) @(posedge clk);
        sent++;
        if (s)
            n_starts++;
    endtask

    // Stop sending, wait for every result, then let the engine settle
    task automatic wait_idle();
        din.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    // Register write request; valid stays high for back-to-back writes
    task automatic write_reg(logic [CFG_ADDR_W-1:0] a, dword_t v);
        cfg.valid <= 1'b1;
        cfg.addr  <= a;
        cfg.data  <= v;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        n_writes++;
    endtask

    // Write the selected registers; upper bits of 32-bit registers get junk
    task automatic load_settings(cc20_cfg_t s, logic [7:0] sel);
        if (sel[0]) write_reg(CFG_KEY0, s.key0);
        if (sel[1]) write_reg(CFG_KEY1, s.key1);
        if (sel[2]) write_reg(CFG_KEY2, s.key2);
        if (sel[3]) write_reg(CFG_KEY3, s.key3);
        if (sel[4]) write_reg(CFG_NONCE_LO, s.nonce_lo);
        if (sel[5]) write_reg(CFG_NONCE_HI, {$urandom, s.nonce_hi});
        if (sel[6]) write_reg(CFG_INIT_CTR, {$urandom, s.init_ctr});
        if (sel[7]) write_reg(CFG_UNUSED, rand_dword());
        cfg.valid <= 1'b0;
        n_phases++;
    endtask

    // Well-formed message: full words, last one possibly partial
    task automatic send_message(int len, bit with_start);
        int i;
        for (i = 0; i < len; i++)
            send_req(rand_dword(), with_start && (i == 0),
                     (i == len - 1) ? COUNT_W'($urandom_range(1, 8)) : FULL_COUNT);
    endtask

    initial
    begin
        cc20_cfg_t  s;
        logic [7:0] sel;
        int         r;
        int         len;

        rst_n          <= 1'b0;
        din.valid      <= 1'b0;
        din.data_in    <= '0;
        din.start_req  <= 1'b0;
        din.byte_count <= '0;
        cfg.valid      <= 1'b0;
        cfg.addr       <= '0;
        cfg.data       <= '0;
        eager          = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: all-zero key, nonce and counter
        send_req('0, 1'b1, FULL_COUNT);
        wait_idle();

        // known-answer key/nonce, then the count corner cases
        s.key0     = 64'h0706_0504_0302_0100;
        s.key1     = 64'h0f0e_0d0c_0b0a_0908;
        s.key2     = 64'h1716_1514_1312_1110;
        s.key3     = 64'h1f1e_1d1c_1b1a_1918;
        s.nonce_lo = 64'h4a00_0000_0900_0000;
        s.nonce_hi = 32'h0;
        s.init_ctr = 32'h1;
        load_settings(s, 8'h7F);
        send_req('0, 1'b1, FULL_COUNT);
        send_req('1, 1'b0, FULL_COUNT);
        send_req(rand_dword(), 1'b0, 4'd0);     // zero count
        send_req(rand_dword(), 1'b0, 4'd9);     // count above eight
        send_req(rand_dword(), 1'b0, 4'd15);
        send_req(rand_dword(), 1'b0, 4'd1);     // partial word mid-message
        send_req(rand_dword(), 1'b0, 4'd7);
        send_req(rand_dword(), 1'b0, FULL_COUNT);
        send_req(rand_dword(), 1'b0, FULL_COUNT);
        wait_idle();

        // all-ones settings mid-block: current block must stay in use,
        // then restart at the top counter value and wrap to zero
        load_settings('1, 8'hFF);
        eager = 1'b1;
        repeat (6) send_req(rand_dword(), 1'b0, FULL_COUNT);
        send_message(9, 1'b1);
        eager = 1'b0;

        // random phases
        while (sent < ITEMS)
        begin
            wait_idle();
            s   = rand_settings();
            sel = 8'($urandom);
            if ($urandom_range(0, 3) == 0)
                sel = 8'hFF;
            load_settings(s, sel);
            repeat ($urandom_range(2, 8))
            begin
                eager = ($urandom_range(0, 3) == 0);
                r = $urandom_range(0, 99);
                if (r < 50)
                    len = $urandom_range(1, 8);
                else if (r < 85)
                    len = $urandom_range(9, 24);
                else if (r < 97)
                    len = $urandom_range(25, 64);
                else
                    len = $urandom_range(65, 130);
                r = $urandom_range(0, 99);
                if (r < 75)
                    send_message(len, 1'b1);
                else if (r < 85)
                    send_message(len, 1'b0);    // continues the previous stream
                else
                begin
                    // noise: any count, random restarts
                    repeat ($urandom_range(1, 4))
                        send_req(rand_dword(), $urandom_range(0, 3) == 0,
                                 COUNT_W'($urandom_range(0, 15)));
                end
            end
        end
        eager = 1'b0;
        wait_idle();

        $display("Covered %0d message words with %0d restarts under %0d register settings",
                 sent, n_starts, n_phases);
        $display("(%0d register writes), with random stalls on both sides.", n_writes);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* chacha20_stream_xor.f */
hw/rtl/cc20_pkg.sv
hw/rtl/cc20_if.sv
hw/rtl/cc20_qr.sv
hw/rtl/cc20_core.sv
hw/rtl/chacha20_stream_xor.sv
hw/rtl/cc20_checker.sv
verif/cc20_xor_scoreboard.sv
verif/tb_top.sv
